// File: src/mbss_pkg.sv
// ----------------------------------------------------------------------------
// mbss_pkg
// Shared types and constants for the masked byte signature search block.
// ----------------------------------------------------------------------------
package mbss_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned PATTERN_W    = 64;
  localparam int unsigned WILD_W       = 8;
  localparam int unsigned LEN_W        = 4;
  localparam int unsigned OUT_OFFSET_W = 32;
  localparam int unsigned CFG_IDX_W    = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD_BITS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD_ENABLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH  = 2'd3;

  typedef struct packed {
    logic [PATTERN_W-1:0] pattern_bytes;
    logic [WILD_W-1:0]    wildcard_bits;
    logic                 wildcard_enable;
    logic [LEN_W-1:0]     pattern_length;
  } cfg_t;

endpackage

// File: src/mbss_cfg_regs.sv
// ----------------------------------------------------------------------------
// mbss_cfg_regs
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module mbss_cfg_regs
  import mbss_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PATTERN_W-1:0] cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PATTERN_BYTES:   cfg_d.pattern_bytes   = cfg_data_i;
        CFG_WILDCARD_BITS:   cfg_d.wildcard_bits   = cfg_data_i[WILD_W-1:0];
        CFG_WILDCARD_ENABLE: cfg_d.wildcard_enable = cfg_data_i[0];
        CFG_PATTERN_LENGTH:  cfg_d.pattern_length  = cfg_data_i[LEN_W-1:0];
        default:             cfg_d                 = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_bytes   <= '0;
      cfg_q.wildcard_bits   <= '0;
      cfg_q.wildcard_enable <= 1'b0;
      cfg_q.pattern_length  <= LEN_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: src/mbss_window.sv
// ----------------------------------------------------------------------------
// mbss_window
// Byte shift window, fill count and saturating buffer offset counter.
// ----------------------------------------------------------------------------
module mbss_window
  import mbss_pkg::*;
#(
  parameter int unsigned MAX_PATTERN  = 8,
  parameter int unsigned OFFSET_WIDTH = 32,
  localparam int unsigned FILL_W      = $clog2(MAX_PATTERN + 1)
)(
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic [BYTE_W-1:0]                  data_byte_i,
  input  logic                               last_byte_i,
  output logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_next_o,
  output logic [FILL_W-1:0]                  fill_next_o,
  output logic [OFFSET_WIDTH-1:0]            position_o
);

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_q;
  logic [FILL_W-1:0]                  fill_q, fill_d;
  logic [OFFSET_WIDTH-1:0]            pos_q, pos_d;

  // Incoming byte enters at entry 0, older bytes move up by one
  always_comb begin
    win_next_o[0] = data_byte_i;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_next_o[i] = win_q[i-1];
    end
  end

  assign fill_next_o = (fill_q == FILL_W'(MAX_PATTERN)) ? fill_q : fill_q + FILL_W'(1);
  assign position_o  = pos_q;

  always_comb begin
    fill_d = fill_next_o;
    pos_d  = pos_q;
    if (last_byte_i) begin
      fill_d = '0;
      pos_d  = '0;
    end else if (pos_q != '1) begin
      pos_d  = pos_q + OFFSET_WIDTH'(1);
    end
  end

  // Window contents need no clear: entries above the fill count are never compared
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q <= win_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
    end else if (accept_i) begin
      fill_q <= fill_d;
      pos_q  <= pos_d;
    end
  end

endmodule

// File: src/mbss_matcher.sv
// ----------------------------------------------------------------------------
// mbss_matcher
// Parallel masked compare of the window against the signature, per length.
// ----------------------------------------------------------------------------
module mbss_matcher
  import mbss_pkg::*;
#(
  parameter int unsigned MAX_PATTERN  = 8,
  parameter int unsigned OFFSET_WIDTH = 32,
  localparam int unsigned FILL_W      = $clog2(MAX_PATTERN + 1),
  localparam int unsigned EXT_W       = (OFFSET_WIDTH > OUT_OFFSET_W) ? OFFSET_WIDTH
                                                                       : OUT_OFFSET_W
)(
  input  cfg_t                               cfg_i,
  input  logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_i,
  input  logic [FILL_W-1:0]                  fill_i,
  input  logic [OFFSET_WIDTH-1:0]            position_i,
  output logic                               found_o,
  output logic [OUT_OFFSET_W-1:0]            offset_o
);

  logic [LEN_W-1:0]        len_eff;
  logic [MAX_PATTERN:1]    len_hit;
  logic [WILD_W-1:0]       wild;
  logic [OFFSET_WIDTH-1:0] start;
  logic [EXT_W-1:0]        start_ext;

  // Clamp length to window depth
  assign len_eff = (cfg_i.pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                                : cfg_i.pattern_length;
  assign wild    = cfg_i.wildcard_enable ? cfg_i.wildcard_bits : '0;

  // One fixed-index compare per candidate length; signature byte k meets
  // window entry len-1-k
  always_comb begin
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      len_hit[l] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (!wild[k] &&
            (win_i[l-1-k] != cfg_i.pattern_bytes[BYTE_W*k +: BYTE_W])) begin
          len_hit[l] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    found_o = 1'b0;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      if ((len_eff == LEN_W'(l)) && (LEN_W'(fill_i) >= len_eff)) begin
        found_o = len_hit[l];
      end
    end
  end

  assign start     = position_i - OFFSET_WIDTH'(len_eff - LEN_W'(1));
  assign start_ext = EXT_W'(start);
  assign offset_o  = start_ext[OUT_OFFSET_W-1:0];

endmodule

// File: src/masked_byte_signature_search_top.sv
// ----------------------------------------------------------------------------
// masked_byte_signature_search_top
// Streaming wildcard byte signature search, one byte per transfer.
// ----------------------------------------------------------------------------
// Result: registered; it appears in the cycle after the byte transfer that causes it.
// Throughput: one byte per cycle while the result channel does not stall; the window
//   compare and offset subtract fit between the window and result registers.
// Reset: asynchronous, active low; clears control state and loads register
//   defaults (pattern length one, wildcards off). No clearing pass.
// ----------------------------------------------------------------------------
module masked_byte_signature_search_top
  import mbss_pkg::*;
#(
  parameter int unsigned MAX_PATTERN  = 8,
  parameter int unsigned OFFSET_WIDTH = 32
)(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [PATTERN_W-1:0]    cfg_data_i,
  // Byte input channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [BYTE_W-1:0]       data_byte_i,
  input  logic                    last_byte_i,
  // Result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    match_found_o,
  output logic [OUT_OFFSET_W-1:0] match_offset_o,
  output logic                    frame_end_o
);

  localparam int unsigned FILL_W = $clog2(MAX_PATTERN + 1);

  cfg_t                               cfg;
  logic                               in_accept;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_next;
  logic [FILL_W-1:0]                  fill_next;
  logic [OFFSET_WIDTH-1:0]            position;
  logic                               found;
  logic [OUT_OFFSET_W-1:0]            offset;

  logic                    out_valid_q, out_valid_d;
  logic                    found_q;
  logic [OUT_OFFSET_W-1:0] offset_q;
  logic                    end_q;

  // Take a new byte whenever the result register is empty or drains this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  mbss_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mbss_window #(
    .MAX_PATTERN  (MAX_PATTERN),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .win_next_o  (win_next),
    .fill_next_o (fill_next),
    .position_o  (position)
  );

  mbss_matcher #(
    .MAX_PATTERN  (MAX_PATTERN),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_matcher (
    .cfg_i      (cfg),
    .win_i      (win_next),
    .fill_i     (fill_next),
    .position_i (position),
    .found_o    (found),
    .offset_o   (offset)
  );

  // Result register: load on a match or on the final byte, drop after transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept && (found || last_byte_i)) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: hold until the next loading transfer; offset reads zero without a match
  always_ff @(posedge clk_i) begin
    if (in_accept && (found || last_byte_i)) begin
      found_q  <= found;
      offset_q <= found ? offset : '0;
      end_q    <= last_byte_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_found_o  = found_q;
  assign match_offset_o = offset_q;
  assign frame_end_o    = end_q;

endmodule

// File: tb/mbss_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mbss_checker
// Passive scoreboard for the masked byte signature search block: tracks
// register writes, predicts the result of every byte transfer and compares
// each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module mbss_checker
  import mbss_pkg::*;
#(
  parameter int unsigned MAX_PATTERN  = 8,
  parameter int unsigned OFFSET_WIDTH = 32
)(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [PATTERN_W-1:0]    cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [BYTE_W-1:0]       data_byte_i,
  input  logic                    last_byte_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic                    match_found_i,
  input  logic [OUT_OFFSET_W-1:0] match_offset_i,
  input  logic                    frame_end_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      results_o,
  output int                      matches_o
);

  typedef struct packed {
    logic                    found;
    logic [OUT_OFFSET_W-1:0] offset;
    logic                    buf_end;
  } scan_result_t;

  scan_result_t predicted_hits_q[$];

  // Shadow registers and search state
  logic [PATTERN_W-1:0]    sig_bytes_q;
  logic [WILD_W-1:0]       wild_mask_q;
  logic                    wild_on_q;
  logic [LEN_W-1:0]        sig_len_q;
  logic [BYTE_W-1:0]       window_q [8];
  int unsigned             fill_q;
  logic [OFFSET_WIDTH-1:0] position_q;

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    fail_count_o++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scan_model
    logic                    hit;
    logic [OFFSET_WIDTH-1:0] start;
    int unsigned             eff_len;
    scan_result_t            exp_r;
    if (!rst_ni) begin
      predicted_hits_q.delete();
      sig_bytes_q  = '0;
      wild_mask_q  = '0;
      wild_on_q    = 1'b0;
      sig_len_q    = 4'd1;
      for (int i = 0; i < 8; i++) window_q[i] = '0;
      fill_q       = 0;
      position_q   = '0;
      fail_count_o = 0;
      pending_o    = 0;
      results_o    = 0;
      matches_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PATTERN_BYTES:   sig_bytes_q = cfg_data_i;
          CFG_WILDCARD_BITS:   wild_mask_q = cfg_data_i[WILD_W-1:0];
          CFG_WILDCARD_ENABLE: wild_on_q   = cfg_data_i[0];
          CFG_PATTERN_LENGTH:  sig_len_q   = cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        // shift the byte in, newest at entry 0
        for (int i = 7; i > 0; i--) window_q[i] = window_q[i-1];
        window_q[0] = data_byte_i;
        if (fill_q < MAX_PATTERN) fill_q++;
        eff_len = (sig_len_q > MAX_PATTERN) ? MAX_PATTERN : sig_len_q;
        hit   = 1'b0;
        start = '0;
        if (eff_len > 0 && fill_q >= eff_len) begin
          hit = 1'b1;
          for (int k = 0; k < eff_len; k++) begin
            if (!(wild_on_q && wild_mask_q[k]) &&
                window_q[eff_len-1-k] != sig_bytes_q[8*k +: 8])
              hit = 1'b0;
          end
          if (hit) start = position_q - OFFSET_WIDTH'(eff_len - 1);
        end
        if (last_byte_i) begin
          for (int i = 0; i < 8; i++) window_q[i] = '0;
          fill_q     = 0;
          position_q = '0;
        end else if (position_q != '1) begin
          position_q++;
        end
        if (hit || last_byte_i) begin
          exp_r.found   = hit;
          exp_r.offset  = hit ? OUT_OFFSET_W'(start) : '0;
          exp_r.buf_end = last_byte_i;
          predicted_hits_q.insert(predicted_hits_q.size(), exp_r);
        end
      end

      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (match_found_i) matches_o++;
        if (predicted_hits_q.size() == 0) begin
          flag_mismatch("unexpected result, match_found", 32'd0, 32'(match_found_i));
        end else begin
          exp_r = predicted_hits_q.pop_front();
          if (match_found_i !== exp_r.found)
            flag_mismatch("match_found", 32'(exp_r.found), 32'(match_found_i));
          if (match_offset_i !== exp_r.offset)
            flag_mismatch("match_offset", exp_r.offset, match_offset_i);
          if (frame_end_i !== exp_r.buf_end)
            flag_mismatch("frame_end", 32'(exp_r.buf_end), 32'(frame_end_i));
        end
      end
      pending_o = predicted_hits_q.size();
    end
  end

endmodule

// File: tb/tb_masked_byte_signature_search_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_masked_byte_signature_search_top
// Stimulus and verdict for the masked byte signature search block. Runs a
// short directed sequence, then a series of register settings, each with
// buffers built mostly from whole and broken signatures. Both channels idle
// at random; the checker beside the block does all prediction and compare.
// ----------------------------------------------------------------------------
module tb_masked_byte_signature_search_top
  import mbss_pkg::*;
();

  localparam int unsigned IDLE_PCT     = 38;
  localparam int unsigned NUM_PHASES   = 12;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned DRAIN_CYCLES = 3;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [PATTERN_W-1:0]    cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [BYTE_W-1:0]       data_byte_i;
  logic                    last_byte_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    match_found_o;
  logic [OUT_OFFSET_W-1:0] match_offset_o;
  logic                    frame_end_o;

  int fail_count;
  int pending;
  int results_seen;
  int matches_seen;

  // Set during the stretch where neither side idles
  bit no_idle;

  int bytes_sent;
  int frames_sent;
  int settings_loaded;

  // Local copy of the current settings, used to build buffers that hit
  logic [PATTERN_W-1:0] cur_pat;
  logic [WILD_W-1:0]    cur_wild;
  logic [LEN_W-1:0]     cur_len;

  logic [BYTE_W-1:0]    frame_bytes[$];

  masked_byte_signature_search_top #(
    .MAX_PATTERN  (8),
    .OFFSET_WIDTH (32)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .match_found_o  (match_found_o),
    .match_offset_o (match_offset_o),
    .frame_end_o    (frame_end_o)
  );

  mbss_checker #(
    .MAX_PATTERN  (8),
    .OFFSET_WIDTH (32)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .match_found_i  (match_found_o),
    .match_offset_i (match_offset_o),
    .frame_end_i    (frame_end_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results_seen),
    .matches_o      (matches_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  // Result side: stall at random, except during the no-idle stretch
  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Push one byte through the input channel. Insert random idle cycles first;
  // hold valid and payload until the transfer completes. Valid is left high so
  // a following byte goes out back to back.
  task automatic send_byte(input logic [BYTE_W-1:0] value, input logic is_last);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= value;
    last_byte_i <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  // One register transfer; valid stays high for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [PATTERN_W-1:0] value);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Drop input valid, wait for every predicted result to drain, then let the
  // block settle bytes that produce no result.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Load all four registers while idle. Fill unused upper data bits with
  // noise so register masking gets exercised.
  task automatic load_settings(input logic [PATTERN_W-1:0] pat,
                               input logic [WILD_W-1:0] wild,
                               input logic wild_en,
                               input logic [LEN_W-1:0] len);
    logic [PATTERN_W-1:0] noise;
    wait_drained();
    noise = {$urandom, $urandom};
    write_reg(CFG_PATTERN_BYTES, pat);
    write_reg(CFG_WILDCARD_BITS, {noise[PATTERN_W-1:WILD_W], wild});
    write_reg(CFG_WILDCARD_ENABLE, {noise[PATTERN_W-1:1], wild_en});
    write_reg(CFG_PATTERN_LENGTH, {noise[PATTERN_W-1:LEN_W], len});
    cfg_valid_i <= 1'b0;
    cur_pat     = pat;
    cur_wild    = wild;
    cur_len     = len;
    settings_loaded++;
  endtask

  // Send the queued buffer, flagging its final byte.
  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frames_sent++;
  endtask

  // Build a buffer mostly from whole signatures (random bytes in the wildcard
  // slots), broken signature prefixes and bytes of the signature alphabet,
  // with some full-range noise. Truncation at the end leaves matches that
  // would run past the buffer.
  task automatic build_frame(input int len);
    int          pick;
    int          sig_n;
    int          cut;
    logic [7:0]  sig_byte;
    frame_bytes.delete();
    sig_n = (cur_len == 0) ? $urandom_range(1, 8) : ((cur_len > 8) ? 8 : cur_len);
    while (frame_bytes.size() < len) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        for (int k = 0; k < sig_n; k++) begin
          sig_byte = cur_pat[8*k +: 8];
          if (cur_wild[k] && $urandom_range(1)) sig_byte = 8'($urandom);
          frame_bytes.insert(frame_bytes.size(), sig_byte);
        end
      end else if (pick < 65) begin
        cut = $urandom_range(sig_n - 1, 0);
        for (int k = 0; k < cut; k++) frame_bytes.insert(frame_bytes.size(), cur_pat[8*k +: 8]);
        frame_bytes.insert(frame_bytes.size(), 8'($urandom));
      end else if (pick < 85) begin
        frame_bytes.insert(frame_bytes.size(), cur_pat[8*$urandom_range(7) +: 8]);
      end else begin
        frame_bytes.insert(frame_bytes.size(), 8'($urandom));
      end
    end
    while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
  endtask

  initial begin
    logic [PATTERN_W-1:0] pat;
    logic [WILD_W-1:0]    wild;
    logic                 wild_en;
    logic [LEN_W-1:0]     len;
    logic [PATTERN_W-1:0] dir_pat;
    int                   phase_items;
    int                   frame_len;

    // Known values on the block's inputs from time zero; result ready follows
    // from the first edge
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_PATTERN_BYTES;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    data_byte_i <= '0;
    last_byte_i <= 1'b0;
    no_idle     <= 1'b0;
    cur_pat     = '0;
    cur_wild    = '0;
    cur_len     = 4'd1;
    bytes_sent      = 0;
    frames_sent     = 0;
    settings_loaded = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults (one-byte signature 0x00, wildcards off).
    // Match on a middle byte, a final byte with no match, and a one-byte
    // buffer whose only byte both matches and ends it.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h00, 1'b1);

    // Directed: full eight-byte signature with extreme bytes and one wildcard
    // slot. Send it with a foreign byte in the wildcard slot, then a prefix
    // cut short by the end of the buffer, which must not report.
    dir_pat = 64'hFF00_7F80_0155_AA3C;
    load_settings(dir_pat, 8'b0000_0100, 1'b1, 4'd8);
    for (int k = 0; k < 8; k++)
      send_byte((k == 2) ? 8'h11 : dir_pat[8*k +: 8], 1'b0);
    for (int k = 0; k < 3; k++) send_byte(dir_pat[8*k +: 8], 1'b0);
    send_byte(dir_pat[8*3 +: 8], 1'b1);

    // Directed: wildcards off, signature completed by the final byte
    load_settings(dir_pat, 8'b0000_0100, 1'b0, 4'd8);
    for (int k = 0; k < 8; k++) send_byte(dir_pat[8*k +: 8], k == 7);

    // Random phases, each under its own register setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      pat     = {$urandom, $urandom};
      wild    = WILD_W'($urandom);
      wild_en = 1'($urandom_range(1));
      len     = LEN_W'(($urandom_range(99) < 85) ? $urandom_range(8, 1)
                                                 : $urandom_range(15, 0));
      case (phase)
        0: begin wild_en = 1'b0; len = 4'd1; end
        1: begin pat = '1; wild = '0; wild_en = 1'b0; len = 4'd8; end
        2: begin pat = '0; wild = '1; wild_en = 1'b1; len = 4'd8; end
        3: len = 4'd0;
        4: begin wild_en = 1'b1; len = 4'd15; end
        5: begin wild_en = 1'b0; len = 4'd3; end
        6: begin wild = '0; wild_en = 1'b1; len = 4'd5; end
        7: begin pat = {8{pat[7:0]}}; wild_en = 1'b1; len = LEN_W'($urandom_range(8, 2)); end
        8: len = 4'd9;
        default: ;
      endcase
      // Hold both sides busy through phases six and seven
      no_idle <= (phase == 6 || phase == 7);
      load_settings(pat, wild, wild_en, len);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        frame_len = ($urandom_range(99) < 90) ? $urandom_range(24, 1) : $urandom_range(300, 60);
        // Trim the last buffer so each phase sends its share and no more
        if (frame_len > int'(PHASE_ITEMS) - phase_items)
          frame_len = int'(PHASE_ITEMS) - phase_items;
        build_frame(frame_len);
        phase_items += frame_bytes.size();
        send_frame();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);

    $display("Sent %0d bytes in %0d buffers under %0d register settings.",
             bytes_sent, frames_sent, settings_loaded);
    $display("Checked %0d results, %0d of them matches; %0d left unanswered.",
             results_seen, matches_seen, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/mbss_pkg.sv
src/mbss_cfg_regs.sv
src/mbss_window.sv
src/mbss_matcher.sv
src/masked_byte_signature_search_top.sv
tb/mbss_checker.sv
tb/tb_masked_byte_signature_search_top.sv
